/* hdl/svptw_pkg.sv */
// shared types, codes and leaf checks for the sv32 page table walker
package svptw_pkg;

   localparam int PAGE_SHIFT  = 12;
   localparam int SUPER_SHIFT = 22;
   localparam int VPN_WIDTH   = 10;
   localparam int ADDR_WIDTH  = 32;
   localparam int PPN_WIDTH   = 22;

   // config register indexes
   localparam int CSR_INDEX_WIDTH = 1;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRANSLATE_ENABLE = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_ROOT_PAGE_NUMBER = 1'd1;

   // walk phases
   localparam logic [1:0] PHASE_IDLE = 2'd0;
   localparam logic [1:0] PHASE_L1   = 2'd1;
   localparam logic [1:0] PHASE_L0   = 2'd2;

   localparam logic MODE_REQUEST = 1'b0;
   localparam logic MODE_PTE     = 1'b1;

   localparam logic KIND_PTE_READ = 1'b0;
   localparam logic KIND_DONE     = 1'b1;

   localparam logic [1:0] PRIV_USER       = 2'd0;
   localparam logic [1:0] PRIV_SUPERVISOR = 2'd1;
   localparam logic [1:0] PRIV_MACHINE    = 2'd3;

   // pte bit positions
   localparam int PTE_V = 0;
   localparam int PTE_R = 1;
   localparam int PTE_W = 2;
   localparam int PTE_X = 3;
   localparam int PTE_U = 4;
   localparam int PTE_A = 6;
   localparam int PTE_D = 7;

   // one classified input item as it sits in the queue
   typedef struct packed {
      logic                  mode;
      logic [ADDR_WIDTH-1:0] word;          // vaddr for a request, pte for entry data
      logic                  store_access;
      logic                  fetch_access;
      logic [1:0]            priv;
      logic                  untranslated;
      logic [ADDR_WIDTH-1:0] l1_address;
      logic                  pte_bad;
      logic                  pte_pointer;
   } item_type;

   typedef struct packed {
      logic [1:0] phase;
      logic       pop;
   } back_status_type;

   function automatic logic leaf_ok(input logic [ADDR_WIDTH-1:0] pte,
                                    input logic st,
                                    input logic ex,
                                    input logic [1:0] priv);
      logic ok;
      ok = 1'b1;
      if (!st && !ex && !pte[PTE_R]) ok = 1'b0;
      if (st && !pte[PTE_W]) ok = 1'b0;
      if (ex && !pte[PTE_X]) ok = 1'b0;
      if (priv == PRIV_SUPERVISOR && pte[PTE_U]) ok = 1'b0;
      if (priv == PRIV_USER && !pte[PTE_U]) ok = 1'b0;
      if (!pte[PTE_A] || (st && !pte[PTE_D])) ok = 1'b0;
      return ok;
   endfunction

endpackage

/* hdl/svptw_front.sv */
// front end: classifies an incoming request or pte word into a queue entry
module svptw_front (
   input  logic                                     req_mode,
   input  logic [svptw_pkg::ADDR_WIDTH-1:0]         req_vaddr,
   input  logic                                     req_is_store,
   input  logic                                     req_is_execute,
   input  logic [1:0]                               req_priv_level,
   input  logic [svptw_pkg::ADDR_WIDTH-1:0]         req_pte_data,
   input  logic                                     translate_enable,
   input  logic [svptw_pkg::PPN_WIDTH-1:0]          root_page_number,
   output svptw_pkg::item_type                      item
);

   logic [svptw_pkg::VPN_WIDTH-1:0] vpn1;

   assign vpn1 = req_vaddr[svptw_pkg::ADDR_WIDTH-1:svptw_pkg::SUPER_SHIFT];

   always_comb begin
      item.mode         = req_mode;
      item.word         = (req_mode == svptw_pkg::MODE_PTE) ? req_pte_data : req_vaddr;
      item.store_access = req_is_store;
      item.fetch_access = req_is_execute;
      item.priv         = req_priv_level;
      item.untranslated = (req_priv_level == svptw_pkg::PRIV_MACHINE) || !translate_enable;
      // root << 12 plus vpn1 * 4, truncated; low bits never carry
      item.l1_address   = {root_page_number[svptw_pkg::ADDR_WIDTH-svptw_pkg::PAGE_SHIFT-1:0],
                           vpn1, 2'b00};
      item.pte_bad      = !req_pte_data[svptw_pkg::PTE_V]
                          || (!req_pte_data[svptw_pkg::PTE_R] && req_pte_data[svptw_pkg::PTE_W]);
      item.pte_pointer  = !req_pte_data[svptw_pkg::PTE_R] && !req_pte_data[svptw_pkg::PTE_X];
   end

endmodule

/* hdl/svptw_queue.sv */
// short fifo between the front end and the walk engine
module svptw_queue #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  svptw_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output svptw_pkg::item_type head_item,
   output logic                not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   svptw_pkg::item_type entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

/* hdl/svptw_back.sv */
// walk engine: holds the walk state, checks entries and drives the result register
module svptw_back (
   input  logic                                 clock,
   input  logic                                 reset,
   input  svptw_pkg::item_type                  head_item,
   input  logic                                 head_valid,
   output logic                                 head_pop,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic                                 rsp_kind,
   output logic [svptw_pkg::ADDR_WIDTH-1:0]     rsp_address,
   output logic                                 rsp_page_fault,
   output svptw_pkg::back_status_type           status
);

   logic [1:0]                          phase_ff, phase_in;
   logic [svptw_pkg::ADDR_WIDTH-1:0]    held_vaddr_ff, held_vaddr_in;
   logic                                held_store_ff, held_store_in;
   logic                                held_execute_ff, held_execute_in;
   logic [1:0]                          held_priv_ff, held_priv_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic                                rsp_kind_ff, rsp_kind_in;
   logic [svptw_pkg::ADDR_WIDTH-1:0]    rsp_address_ff, rsp_address_in;
   logic                                rsp_page_fault_ff, rsp_page_fault_in;

   logic                                pop;
   logic                                emit;
   logic                                leaf_good;
   logic [svptw_pkg::VPN_WIDTH-1:0]     vpn0;
   logic [svptw_pkg::PAGE_SHIFT-1:0]    offset;
   logic [svptw_pkg::ADDR_WIDTH-1:0]    pte;

   assign pop    = head_valid && (!rsp_valid_ff || rsp_ready);
   assign pte    = head_item.word;
   assign vpn0   = held_vaddr_ff[svptw_pkg::SUPER_SHIFT-1:svptw_pkg::PAGE_SHIFT];
   assign offset = held_vaddr_ff[svptw_pkg::PAGE_SHIFT-1:0];
   assign leaf_good = svptw_pkg::leaf_ok(pte, held_store_ff, held_execute_ff, held_priv_ff);

   always_comb begin
      phase_in          = phase_ff;
      held_vaddr_in     = held_vaddr_ff;
      held_store_in     = held_store_ff;
      held_execute_in   = held_execute_ff;
      held_priv_in      = held_priv_ff;
      emit              = 1'b0;
      rsp_kind_in       = svptw_pkg::KIND_DONE;
      rsp_address_in    = '0;
      rsp_page_fault_in = 1'b0;

      if (pop) begin
         if (head_item.mode == svptw_pkg::MODE_REQUEST) begin
            held_vaddr_in   = head_item.word;
            held_store_in   = head_item.store_access;
            held_execute_in = head_item.fetch_access;
            held_priv_in    = head_item.priv;
            emit            = 1'b1;
            if (head_item.untranslated) begin
               phase_in       = svptw_pkg::PHASE_IDLE;
               rsp_address_in = head_item.word;
            end else begin
               phase_in       = svptw_pkg::PHASE_L1;
               rsp_kind_in    = svptw_pkg::KIND_PTE_READ;
               rsp_address_in = head_item.l1_address;
            end
         end else begin
            unique case (phase_ff)
               svptw_pkg::PHASE_L1: begin
                  emit = 1'b1;
                  if (head_item.pte_bad) begin
                     phase_in          = svptw_pkg::PHASE_IDLE;
                     rsp_page_fault_in = 1'b1;
                  end else if (head_item.pte_pointer) begin
                     phase_in       = svptw_pkg::PHASE_L0;
                     rsp_kind_in    = svptw_pkg::KIND_PTE_READ;
                     rsp_address_in = {pte[29:10], vpn0, 2'b00};
                  end else if (!leaf_good || (pte[19:10] != '0)) begin
                     // bad permission or misaligned superpage
                     phase_in          = svptw_pkg::PHASE_IDLE;
                     rsp_page_fault_in = 1'b1;
                  end else begin
                     phase_in       = svptw_pkg::PHASE_IDLE;
                     rsp_address_in = {pte[29:20], vpn0, offset};
                  end
               end
               svptw_pkg::PHASE_L0: begin
                  emit     = 1'b1;
                  phase_in = svptw_pkg::PHASE_IDLE;
                  if (head_item.pte_bad || head_item.pte_pointer || !leaf_good) begin
                     rsp_page_fault_in = 1'b1;
                  end else begin
                     rsp_address_in = {pte[29:10], offset};
                  end
               end
               default: begin
                  // entry data with no walk in progress is dropped
                  phase_in = svptw_pkg::PHASE_IDLE;
               end
            endcase
         end
      end

      rsp_valid_in = pop ? emit : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= svptw_pkg::PHASE_IDLE;
         held_vaddr_ff   <= '0;
         held_store_ff   <= 1'b0;
         held_execute_ff <= 1'b0;
         held_priv_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         held_vaddr_ff   <= held_vaddr_in;
         held_store_ff   <= held_store_in;
         held_execute_ff <= held_execute_in;
         held_priv_ff    <= held_priv_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && emit) begin
         rsp_kind_ff       <= rsp_kind_in;
         rsp_address_ff    <= rsp_address_in;
         rsp_page_fault_ff <= rsp_page_fault_in;
      end
   end

   assign head_pop       = pop;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_address    = rsp_address_ff;
   assign rsp_page_fault = rsp_page_fault_ff;
   assign status.phase   = phase_ff;
   assign status.pop     = pop;

endmodule

/* hdl/sv32_page_table_walker_core.sv */
// top level of the sv32 page table walker: config registers, front, queue, walk engine
//
// req_ channel: mode 0 starts a translation (vaddr, the access kind and
// priv_level); mode 1 hands in the pte word that memory returned for the
// last read the block asked for. rsp_ channel: kind 0 asks for the pte at
// address, kind 1 ends a translation with the physical address or a page
// fault. A request in machine mode or with translation off finishes at once.
// Every item takes one transfer in; most give one transfer out, entry data
// with no walk in progress gives none. Each item is registered in the queue
// and then in the result register before rsp_valid rises; one item per cycle
// is sustained while rsp_ready stays high. A two-entry queue splits the front
// from the engine, so req_ready stays high while a result waits on a stalled
// receiver until the queue fills; the engine holds while rsp_valid is high
// and rsp_ready is low. csr_ writes are always taken and must only happen
// with the block idle. Reset clears the config registers, the walk state,
// the queue and rsp_valid.
module sv32_page_table_walker_core #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        req_valid,
   output logic                                        req_ready,
   input  logic                                        req_mode,
   input  logic [svptw_pkg::ADDR_WIDTH-1:0]            req_vaddr,
   input  logic                                        req_is_store,
   input  logic                                        req_is_execute,
   input  logic [1:0]                                  req_priv_level,
   input  logic [svptw_pkg::ADDR_WIDTH-1:0]            req_pte_data,
   output logic                                        rsp_valid,
   input  logic                                        rsp_ready,
   output logic                                        rsp_kind,
   output logic [svptw_pkg::ADDR_WIDTH-1:0]            rsp_address,
   output logic                                        rsp_page_fault,
   input  logic                                        csr_valid,
   output logic                                        csr_ready,
   input  logic [svptw_pkg::CSR_INDEX_WIDTH-1:0]       csr_index,
   input  logic [svptw_pkg::PPN_WIDTH-1:0]             csr_wdata
);

   logic                               translate_enable_ff, translate_enable_in;
   logic [svptw_pkg::PPN_WIDTH-1:0]    root_page_number_ff, root_page_number_in;

   svptw_pkg::item_type        front_item;
   svptw_pkg::item_type        head_item;
   svptw_pkg::back_status_type back_status;
   logic                       queue_full;
   logic                       queue_not_empty;
   logic                       head_pop;

   assign csr_ready = 1'b1;
   assign req_ready = !queue_full;

   always_comb begin
      translate_enable_in = translate_enable_ff;
      root_page_number_in = root_page_number_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            svptw_pkg::CSR_TRANSLATE_ENABLE: translate_enable_in = csr_wdata[0];
            svptw_pkg::CSR_ROOT_PAGE_NUMBER: root_page_number_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         translate_enable_ff <= 1'b0;
         root_page_number_ff <= '0;
      end else begin
         translate_enable_ff <= translate_enable_in;
         root_page_number_ff <= root_page_number_in;
      end
   end

   svptw_front u_front (
      .req_mode         (req_mode),
      .req_vaddr        (req_vaddr),
      .req_is_store     (req_is_store),
      .req_is_execute   (req_is_execute),
      .req_priv_level   (req_priv_level),
      .req_pte_data     (req_pte_data),
      .translate_enable (translate_enable_ff),
      .root_page_number (root_page_number_ff),
      .item             (front_item)
   );

   svptw_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_item (front_item),
      .full      (queue_full),
      .pop       (head_pop),
      .head_item (head_item),
      .not_empty (queue_not_empty)
   );

   svptw_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_item      (head_item),
      .head_valid     (queue_not_empty),
      .head_pop       (head_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_kind       (rsp_kind),
      .rsp_address    (rsp_address),
      .rsp_page_fault (rsp_page_fault),
      .status         (back_status)
   );

   // a fault always ends the transaction with a zero address
   a_fault_is_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_page_fault |-> (rsp_kind == svptw_pkg::KIND_DONE) && (rsp_address == '0))
      else $error("page fault result not final or address nonzero");

   // a pending pte read leaves the walk waiting on an entry
   a_read_means_walking: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == svptw_pkg::KIND_PTE_READ)
      |-> (back_status.phase == svptw_pkg::PHASE_L1) || (back_status.phase == svptw_pkg::PHASE_L0))
      else $error("pte read outstanding with walk idle");

   // a finished translation returns the walk to idle
   a_done_means_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == svptw_pkg::KIND_DONE) |-> back_status.phase == svptw_pkg::PHASE_IDLE)
      else $error("walk still active after a finished translation");

   // an accepted transfer lands in the queue
   a_accept_queues: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> queue_not_empty)
      else $error("accepted item missing from queue");

   // the engine never takes an item while a result is stalled
   a_no_pop_on_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !back_status.pop)
      else $error("item consumed while result stalled");

endmodule
